@@ rtl/swpr_pkg.sv @@
package swpr_pkg;

    localparam int unsigned HDR_BYTES = 8;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_SIZE  = 3'd2,
        ST_CSUM  = 3'd3,
        ST_BIG   = 3'd4
    } t_status;

    typedef enum logic [7:0] {
        CFG_MAX_PAYLOAD = 8'd0,
        CFG_SEQNO_MASK  = 8'd1
    } t_cfg_index;

    localparam logic [9:0]  MAX_PAYLOAD_RST = 10'd1016;
    localparam logic [15:0] SEQNO_MASK_RST  = 16'd128;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        packet_done;
        t_status     status;
        logic        seqbit;
        logic [9:0]  payload_length;
    } t_item;

endpackage

@@ rtl/swpr_front.sv @@
module swpr_front
    import swpr_pkg::*;
#(
    parameter int unsigned MAX_PACKET = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_item       o_item
);

    localparam int unsigned CW = $clog2(MAX_PACKET + 1);

    logic [9:0]    r_max_payload;
    logic [15:0]   r_seqno_mask;
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [15:0]   r_checksum, n_checksum;
    logic [7:0]    r_pending, n_pending;
    logic [15:0]   r_flags, n_flags;
    logic [15:0]   r_stored_sum, n_stored_sum;
    logic [31:0]   r_size, n_size;

    logic          keep;
    logic          in_payload;
    logic [15:0]   sum_final;
    logic [31:0]   payload_len;
    t_status       status;

    assign keep = r_byte_count < CW'(MAX_PACKET);

    always_comb begin
        n_byte_count = r_byte_count;
        n_checksum   = r_checksum;
        n_pending    = r_pending;
        n_flags      = r_flags;
        n_stored_sum = r_stored_sum;
        n_size       = r_size;
        in_payload   = 1'b0;
        if (keep) begin
            if (r_byte_count < CW'(2)) begin
                n_flags = {r_flags[7:0], i_rx_byte};
            end else if (r_byte_count < CW'(4)) begin
                n_stored_sum = {r_stored_sum[7:0], i_rx_byte};
            end else if (r_byte_count < CW'(HDR_BYTES)) begin
                n_size = {r_size[23:0], i_rx_byte};
            end else begin
                in_payload = 1'b1;
            end
            if (!r_byte_count[0]) begin
                n_pending = i_rx_byte;
            end else if (r_byte_count != CW'(3)) begin
                n_checksum = r_checksum ^ {r_pending, i_rx_byte};
            end
            n_byte_count = r_byte_count + CW'(1);
        end
    end

    assign sum_final   = n_byte_count[0] ? (n_checksum ^ {n_pending, 8'h00}) : n_checksum;
    assign payload_len = 32'(n_byte_count) - 32'(HDR_BYTES);

    always_comb begin
        priority if (n_byte_count < CW'(HDR_BYTES)) begin
            status = ST_SHORT;
        end else if (n_size != 32'(n_byte_count)) begin
            status = ST_SIZE;
        end else if (n_stored_sum != sum_final) begin
            status = ST_CSUM;
        end else if (payload_len > 32'(r_max_payload)) begin
            status = ST_BIG;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_item.payload_byte   = i_rx_byte;
        o_item.payload_valid  = in_payload;
        o_item.packet_done    = i_last_byte;
        o_item.status         = i_last_byte ? status : ST_OK;
        o_item.seqbit         = (n_flags & r_seqno_mask) != 16'd0;
        o_item.payload_length = (i_last_byte && status == ST_OK) ? payload_len[9:0] : 10'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_seqno_mask  <= SEQNO_MASK_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_PAYLOAD) begin
                r_max_payload <= i_cfg_data[9:0];
            end else if (i_cfg_index == CFG_SEQNO_MASK) begin
                r_seqno_mask <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_checksum   <= '0;
            r_pending    <= '0;
            r_flags      <= '0;
            r_stored_sum <= '0;
            r_size       <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_byte_count <= '0;
                r_checksum   <= '0;
                r_pending    <= '0;
                r_flags      <= '0;
                r_stored_sum <= '0;
                r_size       <= '0;
            end else begin
                r_byte_count <= n_byte_count;
                r_checksum   <= n_checksum;
                r_pending    <= n_pending;
                r_flags      <= n_flags;
                r_stored_sum <= n_stored_sum;
                r_size       <= n_size;
            end
        end
    end

endmodule

@@ rtl/swpr_fifo.sv @@
module swpr_fifo
    import swpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/swpr_back.sv @@
module swpr_back
    import swpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic        o_packet_done,
    output logic [2:0]  o_status,
    output logic        o_send_ack,
    output logic        o_ack_seqno,
    output logic [9:0]  o_payload_length
);

    logic        r_valid;
    logic        r_expected_seqno;
    t_item       r_item;
    logic        r_send_ack;
    logic        r_ack_seqno;
    logic        n_send_ack;
    logic        n_ack_seqno;
    logic        is_ok;

    assign o_pop = !i_empty && (!r_valid || i_out_ready);
    assign is_ok = i_item.packet_done && i_item.status == ST_OK;

    always_comb begin
        n_send_ack  = 1'b0;
        n_ack_seqno = 1'b0;
        if (i_item.packet_done) begin
            unique case (i_item.status)
                ST_OK: begin
                    n_send_ack  = 1'b1;
                    n_ack_seqno = r_expected_seqno;
                end
                ST_SIZE, ST_CSUM: begin
                    n_send_ack  = 1'b1;
                    n_ack_seqno = ~i_item.seqbit;
                end
                default: begin
                    n_send_ack  = 1'b0;
                    n_ack_seqno = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid          <= 1'b0;
            r_expected_seqno <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (is_ok) begin
                    r_expected_seqno <= ~r_expected_seqno;
                end
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item      <= i_item;
            r_send_ack  <= n_send_ack;
            r_ack_seqno <= n_ack_seqno;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_payload_byte   = r_item.payload_byte;
    assign o_payload_valid  = r_item.payload_valid;
    assign o_packet_done    = r_item.packet_done;
    assign o_status         = r_item.status;
    assign o_send_ack       = r_send_ack;
    assign o_ack_seqno      = r_ack_seqno;
    assign o_payload_length = r_item.payload_length;

endmodule

@@ rtl/stop_and_wait_packet_receiver.sv @@
// Stop-and-wait receiver: takes one datagram byte per cycle while the queue is not full
// and presents one result item per byte through the queue and a back-end register. The
// front end counts bytes, captures the 8-byte header, folds the XOR checksum and
// classifies the packet on the byte marked last; a two-entry queue feeds the back end,
// which issues the ack request on a good, size- or checksum-failed packet and toggles the
// expected sequence bit on a good one. Sustained rate is one byte per cycle without output
// stalls, set by the front end's per-byte header/checksum update. Configuration writes are
// taken at any cycle and must only be issued while the block is idle.
module stop_and_wait_packet_receiver
    import swpr_pkg::*;
#(
    parameter int unsigned MAX_PACKET = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic        o_packet_done,
    output logic [2:0]  o_status,
    output logic        o_send_ack,
    output logic        o_ack_seqno,
    output logic [9:0]  o_payload_length
);

    t_item front_item;
    t_item head_item;
    logic  accept;
    logic  full;
    logic  empty;
    logic  pop;

    assign o_in_ready  = !full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !full;

    swpr_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_item      (front_item)
    );

    swpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (head_item)
    );

    swpr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_item           (head_item),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_payload_byte   (o_payload_byte),
        .o_payload_valid  (o_payload_valid),
        .o_packet_done    (o_packet_done),
        .o_status         (o_status),
        .o_send_ack       (o_send_ack),
        .o_ack_seqno      (o_ack_seqno),
        .o_payload_length (o_payload_length)
    );

endmodule

@@ rtl/swpr_chk.sv @@
module swpr_chk
    import swpr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_packet_done,
    input logic [2:0] o_status,
    input logic       o_send_ack,
    input logic       o_ack_seqno,
    input logic [9:0] o_payload_length
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_done |->
            o_status == ST_OK && !o_send_ack && o_payload_length == 10'd0)
        else $error("status fields set on a non-final byte");

    a_ack_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_ack |-> !o_ack_seqno)
        else $error("ack sequence bit without ack");

    a_ack_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_done && o_send_ack |->
            o_status == ST_OK || o_status == ST_SIZE || o_status == ST_CSUM)
        else $error("ack requested for a status that takes none");

endmodule

bind stop_and_wait_packet_receiver swpr_chk u_chk (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import swpr_pkg::*;

    localparam int unsigned MAX_PACKET  = 1024;
    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned PHASE_ITEMS = 230;
    localparam int unsigned SETTLE      = 6;
    localparam int unsigned WD_LIMIT    = 4000;

    // indexes with no register behind them
    localparam logic [7:0] CFG_NONE_HI = 8'hFE;
    localparam logic [7:0] CFG_NONE_LO = 8'h81;

    typedef enum {CMD_BYTE, CMD_CFG, CMD_HOLD} t_cmd_kind;
    typedef enum {F_NONE, F_SUM, F_SIZE} t_fault;

    typedef struct {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic        is_last;
        logic [7:0]  idx;
        logic [15:0] val;
    } t_link_cmd;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       packet_done;
        t_status    status;
        logic       send_ack;
        logic       ack_seqno;
        logic [9:0] payload_length;
    } t_rx_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = 8'h00;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_payload_byte;
    logic        o_payload_valid;
    logic        o_packet_done;
    logic [2:0]  o_status;
    logic        o_send_ack;
    logic        o_ack_seqno;
    logic [9:0]  o_payload_length;

    stop_and_wait_packet_receiver #(.MAX_PACKET(MAX_PACKET)) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_last_byte      (i_last_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_payload_byte   (o_payload_byte),
        .o_payload_valid  (o_payload_valid),
        .o_packet_done    (o_packet_done),
        .o_status         (o_status),
        .o_send_ack       (o_send_ack),
        .o_ack_seqno      (o_ack_seqno),
        .o_payload_length (o_payload_length)
    );

    always #10 i_clk = ~i_clk;

    // receiver state as the block should hold it
    logic [9:0]  cfg_max_payload = MAX_PAYLOAD_RST;
    logic [15:0] cfg_seq_mask    = SEQNO_MASK_RST;
    logic [10:0] rx_count  = '0;
    logic [15:0] fold_sum  = '0;
    logic [7:0]  hi_byte   = '0;
    logic [15:0] hdr_flags = '0;
    logic [15:0] hdr_sum   = '0;
    logic [31:0] hdr_size  = '0;
    logic        want_seq  = 1'b0;

    t_link_cmd  to_send[$];
    t_rx_result pending_results[$];

    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_cfg      = 0;
    int unsigned mismatches = 0;
    int unsigned queued     = 0;
    int unsigned gen_max    = 32'(MAX_PAYLOAD_RST);
    int unsigned pkt_by_status[5] = '{0, 0, 0, 0, 0};

    function automatic t_rx_result receive_byte(logic [7:0] b, logic is_last);
        t_rx_result  r;
        logic [10:0] pos;
        logic [31:0] len;
        logic [15:0] sum;
        logic        seqbit;
        r = '0;
        r.payload_byte = b;
        if (rx_count < MAX_PACKET) begin
            pos = rx_count;
            if (pos < 2)
                hdr_flags = {hdr_flags[7:0], b};
            else if (pos < 4)
                hdr_sum = {hdr_sum[7:0], b};
            else if (pos < HDR_BYTES)
                hdr_size = {hdr_size[23:0], b};
            else
                r.payload_valid = 1'b1;
            if (!pos[0])
                hi_byte = b;
            else if (pos != 3)
                fold_sum ^= {hi_byte, b};
            rx_count = pos + 11'd1;
        end
        if (is_last) begin
            len = 32'(rx_count);
            sum = fold_sum;
            seqbit = |(hdr_flags & cfg_seq_mask);
            r.packet_done = 1'b1;
            if (len[0])
                sum ^= {hi_byte, 8'h00};
            if (len < HDR_BYTES) begin
                r.status = ST_SHORT;
            end else if (hdr_size != len) begin
                r.status = ST_SIZE;
                r.send_ack = 1'b1;
                r.ack_seqno = ~seqbit;
            end else if (hdr_sum != sum) begin
                r.status = ST_CSUM;
                r.send_ack = 1'b1;
                r.ack_seqno = ~seqbit;
            end else if (len - HDR_BYTES > cfg_max_payload) begin
                r.status = ST_BIG;
            end else begin
                r.status = ST_OK;
                r.send_ack = 1'b1;
                r.ack_seqno = want_seq;
                want_seq = ~want_seq;
                r.payload_length = 10'(len - HDR_BYTES);
            end
            rx_count = '0;
            fold_sum = '0;
            hi_byte = '0;
            hdr_flags = '0;
            hdr_sum = '0;
            hdr_size = '0;
        end
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic is_last);
        t_link_cmd c;
        c.kind = CMD_BYTE;
        c.data = b;
        c.is_last = is_last;
        c.idx = '0;
        c.val = '0;
        to_send.push_back(c);
        queued++;
    endtask

    task automatic queue_cmd(input t_cmd_kind kind, input logic [7:0] idx,
                             input logic [15:0] val);
        t_link_cmd c;
        c.kind = kind;
        c.data = '0;
        c.is_last = 1'b0;
        c.idx = idx;
        c.val = val;
        to_send.push_back(c);
        if (kind == CMD_CFG && idx == CFG_MAX_PAYLOAD)
            gen_max = 32'(val[9:0]);
    endtask

    // keep = 0 sends the whole datagram, otherwise only its first keep bytes
    task automatic queue_packet(input int unsigned plen, input logic [15:0] flags,
                                input t_fault fault, input int unsigned keep);
        logic [7:0]  pk[$];
        logic [63:0] hdr;
        logic [31:0] size_field;
        logic [15:0] sum;
        logic [7:0]  hi;
        int unsigned total, n;
        total = plen + HDR_BYTES;
        size_field = (total > MAX_PACKET) ? MAX_PACKET : total;
        if (fault == F_SIZE)
            size_field = $urandom_range(0, 1) ? $urandom : size_field + $urandom_range(1, 9);
        hdr = {flags, 16'h0000, size_field};
        for (int i = 0; i < HDR_BYTES; i++)
            pk.push_back(hdr[63 - 8 * i -: 8]);
        repeat (plen) pk.push_back(8'($urandom));
        sum = '0;
        hi = '0;
        n = (total > MAX_PACKET) ? MAX_PACKET : total;
        for (int i = 0; i < n; i++) begin
            if (i % 2 == 0)
                hi = pk[i];
            else if (i != 3)
                sum ^= {hi, pk[i]};
        end
        if (n % 2)
            sum ^= {hi, 8'h00};
        if (fault == F_SUM)
            sum ^= 16'h0001 << $urandom_range(0, 15);
        pk[2] = sum[15:8];
        pk[3] = sum[7:0];
        n = (keep != 0) ? keep : total;
        for (int i = 0; i < n; i++)
            queue_byte(pk[i], i == n - 1);
    endtask

    // sender
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned quiet = 0;

    always @(posedge i_clk) begin
        t_link_cmd c;
        logic in_take, cfg_take, nv, ncv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            in_take = i_in_valid && o_in_ready;
            cfg_take = i_cfg_valid && o_cfg_ready;
            if (in_take) begin
                pending_results.push_back(receive_byte(i_rx_byte, i_last_byte));
                n_accepted <= n_accepted + 1;
            end
            if (cfg_take) begin
                n_cfg <= n_cfg + 1;
                if (i_cfg_index == CFG_MAX_PAYLOAD)
                    cfg_max_payload = i_cfg_data[9:0];
                else if (i_cfg_index == CFG_SEQNO_MASK)
                    cfg_seq_mask = i_cfg_data;
            end
            nv = i_in_valid && !in_take;
            ncv = i_cfg_valid && !cfg_take;
            if (!nv && !ncv && !in_take && !cfg_take && n_accepted == n_checked)
                quiet++;
            else
                quiet = 0;
            if (!nv && !ncv && to_send.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    case (to_send[0].kind)
                        CMD_BYTE: begin
                            c = to_send.pop_front();
                            nv = 1'b1;
                            i_rx_byte <= c.data;
                            i_last_byte <= c.is_last;
                            if (burst_left == 0) begin
                                burst_left = $urandom_range(1, 48);
                                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                            end else begin
                                burst_left--;
                            end
                        end
                        CMD_CFG: begin
                            if (quiet >= SETTLE) begin
                                c = to_send.pop_front();
                                ncv = 1'b1;
                                i_cfg_index <= c.idx;
                                i_cfg_data <= c.val;
                            end
                        end
                        default: begin
                            if (quiet >= SETTLE)
                                void'(to_send.pop_front());
                        end
                    endcase
                end
            end
            i_in_valid <= nv;
            i_cfg_valid <= ncv;
        end
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // result side: compare and apply backpressure
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;

    always @(posedge i_clk) begin
        t_rx_result e;
        logic rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_checked <= n_checked + 1;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with none expected, byte %0d", $time,
                             o_payload_byte);
                end else begin
                    e = pending_results.pop_front();
                    if (e.packet_done)
                        pkt_by_status[e.status]++;
                    check_field("payload_byte", e.payload_byte, o_payload_byte);
                    check_field("payload_valid", e.payload_valid, o_payload_valid);
                    check_field("packet_done", e.packet_done, o_packet_done);
                    check_field("status", e.status, o_status);
                    check_field("send_ack", e.send_ack, o_send_ack);
                    check_field("ack_seqno", e.ack_seqno, o_ack_seqno);
                    check_field("payload_length", e.payload_length, o_payload_length);
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = ~i_out_ready;
                2: rdy = ($urandom_range(0, 3) != 0);
                default: rdy = ($urandom_range(0, 9) == 0);
            endcase
            i_out_ready <= rdy;
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
                || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WD_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WD_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned ph, phase_end, roll, plen, cap, leftover;
        logic [15:0] v;

        // directed: too short, empty payload, odd payload, size mismatch
        queue_packet(0, 16'h0000, F_NONE, 1);
        queue_packet(0, 16'hFFFF, F_NONE, 0);
        queue_packet(1, 16'h0000, F_NONE, 0);
        queue_packet(0, 16'h0080, F_SIZE, 0);

        ph = 0;
        while (queued < ITEM_TARGET) begin
            ph++;
            case (ph)
                1: begin
                    queue_cmd(CMD_CFG, CFG_MAX_PAYLOAD, 16'h0000);
                    queue_cmd(CMD_CFG, CFG_SEQNO_MASK, 16'h0001);
                end
                2: begin
                    queue_cmd(CMD_CFG, CFG_MAX_PAYLOAD, 16'hFFFF);
                    queue_cmd(CMD_CFG, CFG_SEQNO_MASK, 16'h8000);
                end
                3: begin
                    queue_cmd(CMD_CFG, CFG_MAX_PAYLOAD, 16'($urandom_range(0, 40)));
                    queue_cmd(CMD_CFG, CFG_SEQNO_MASK, 16'h0000);
                end
                4: begin
                    queue_cmd(CMD_CFG, CFG_NONE_HI, 16'($urandom));
                    queue_cmd(CMD_CFG, CFG_NONE_LO, 16'($urandom));
                    queue_cmd(CMD_CFG, CFG_MAX_PAYLOAD, 16'd1016);
                    queue_cmd(CMD_CFG, CFG_SEQNO_MASK, 16'hFFFF);
                    // runs up to and past the packet limit
                    queue_packet($urandom_range(1009, 1024), 16'($urandom), F_NONE, 0);
                end
                default: begin
                    v = 16'($urandom);
                    queue_cmd(CMD_CFG, CFG_MAX_PAYLOAD,
                              $urandom_range(0, 3) == 0 ? v : 16'($urandom_range(0, 48)));
                    v = $urandom_range(0, 1) ? 16'h0001 << $urandom_range(0, 15)
                                             : 16'($urandom);
                    queue_cmd(CMD_CFG, CFG_SEQNO_MASK, v);
                end
            endcase
            phase_end = queued + PHASE_ITEMS;
            while (queued < phase_end) begin
                cap = (gen_max < 40) ? gen_max + 3 : 40;
                plen = $urandom_range(0, 3) == 0 ? $urandom_range(0, cap) : $urandom_range(0, 16);
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    queue_packet(plen, 16'($urandom), F_NONE, 0);
                else if (roll < 67)
                    queue_packet(plen, 16'($urandom), F_SUM, 0);
                else if (roll < 79)
                    queue_packet(plen, 16'($urandom), F_SIZE, 0);
                else if (roll < 87)
                    queue_packet(plen, 16'($urandom), F_NONE, $urandom_range(1, 7));
                else begin
                    plen = $urandom_range(1, 24);
                    for (int i = 0; i < plen; i++)
                        queue_byte(8'($urandom), i == plen - 1);
                end
                if ($urandom_range(0, 29) == 0)
                    queue_cmd(CMD_HOLD, '0, '0);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(to_send.size() == 0 && !i_in_valid && !i_cfg_valid
                 && n_accepted == n_checked))
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        leftover = pending_results.size();
        if (leftover != 0)
            $display("%0t: %0d expected result items never arrived", $time, leftover);
        $display("run: %0d byte items checked, %0d register writes over %0d settings",
                 n_checked, n_cfg, ph + 1);
        $display("run: packets ok %0d, short %0d, size %0d, checksum %0d, too large %0d",
                 pkt_by_status[ST_OK], pkt_by_status[ST_SHORT], pkt_by_status[ST_SIZE],
                 pkt_by_status[ST_CSUM], pkt_by_status[ST_BIG]);
        if (mismatches == 0 && leftover == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
